>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the i2c slave buffer engine top
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SBE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define SBE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/i2c_sbe_pkg.sv
// ----------------------------------------------------------------------------
// i2c_sbe_pkg
// types and constants of the i2c slave buffer engine
// ----------------------------------------------------------------------------
package i2c_sbe_pkg;

  localparam int unsigned LEVEL_W = 7;

  // item kinds
  localparam logic [1:0] OP_EVENT = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_POP   = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SIXTEEN_BIT   = 2'd0;
  localparam logic [1:0] CFG_CLEAR_ON_END  = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_LIMIT = 2'd2;

  localparam logic [7:0] TIMEOUT_RESET = 8'd50;

  // slave status codes, low three bits masked off
  localparam logic [7:0] ST_NO_INFO     = 8'hF8;
  localparam logic [7:0] ST_ADDR_W      = 8'h60;
  localparam logic [7:0] ST_GCALL_W     = 8'h70;
  localparam logic [7:0] ST_DATA_ACK    = 8'h80;
  localparam logic [7:0] ST_DATA_NACK   = 8'h88;
  localparam logic [7:0] ST_GDATA_ACK   = 8'h90;
  localparam logic [7:0] ST_GDATA_NACK  = 8'h98;
  localparam logic [7:0] ST_STOP        = 8'hA0;
  localparam logic [7:0] ST_ADDR_R      = 8'hA8;
  localparam logic [7:0] ST_TX_ACK      = 8'hB8;
  localparam logic [7:0] ST_TX_NACK     = 8'hC0;
  localparam logic [7:0] ST_TX_LAST     = 8'hC8;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] status_code;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         tx_byte;
    logic               tx_loaded;
    logic               ack_enable;
    logic               bus_restart;
    logic               bus_reset;
    logic [7:0]         rx_byte;
    logic               rx_valid;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
    logic               rx_overflow;
    logic               tx_overflow;
  } out_item_t;

endpackage

>>> hdl/i2c_sbe_ram.sv
// ----------------------------------------------------------------------------
// i2c_sbe_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module i2c_sbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/i2c_slave_buffer_engine_top.sv
// ----------------------------------------------------------------------------
// i2c_slave_buffer_engine_top
// status driven i2c slave buffer engine with receive and transmit fifos
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on in_item_i under in_valid_i / in_stall_o; each item is a bus
//   status event, a host push, a host pop or a tick. Every item gives exactly
//   one result on out_item_o under out_valid_o / out_stall_i.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   the block is idle.
//   Results are registered; a pop or a transmit request that takes a byte
//   from a fifo reads the memory first and then merges the read data in.
//   Throughput: one item per cycle unless the output stalls; no new item is
//   taken while a fifo read is pending in the registered memory read port.
//   Reset: both fifos come up empty with no clearing pass (the memories are
//   not cleared), acknowledge enabled, idle count zero, configuration at its
//   defaults.
//   A stalled result holds in the output register and the input stalls until
//   the result is taken or is being taken in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_slave_buffer_engine_top
  import i2c_sbe_pkg::*;
#(
  parameter int unsigned RX_DEPTH = 64,
  parameter int unsigned TX_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW = $clog2(TX_DEPTH);
  localparam int unsigned RX_CW = $clog2(RX_DEPTH + 1);
  localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);

  // configuration registers
  logic       sixteen_bit_q;
  logic       clear_on_end_q;
  logic [7:0] timeout_limit_q;

  // control state
  logic             ack_on_q, ack_on_d;
  logic             pad_zero_q, pad_zero_d;
  logic [7:0]       idle_q, idle_d;
  logic [RX_AW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [RX_CW-1:0] rx_cnt_q, rx_cnt_d;
  logic [TX_AW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [TX_CW-1:0] tx_cnt_q, tx_cnt_d;

  // pending read and output register
  logic      rd_pend_q, rd_pend_d;
  logic      rd_tx_q, rd_tx_d;
  out_item_t pend_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  // step results
  out_item_t  step_res;
  logic       rd_need;
  logic [7:0] st_code;
  logic       accept;

  // memory ports
  logic       rx_we, rx_re, tx_we, tx_re;
  logic [7:0] rx_rdata, tx_rdata;

  assign in_stall_o = rd_pend_q | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;
  assign st_code    = {in_item_i.status_code[7:3], 3'b000};

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sixteen_bit_q   <= 1'b1;
      clear_on_end_q  <= 1'b0;
      timeout_limit_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIXTEEN_BIT:   sixteen_bit_q   <= cfg_data_i[0];
        CFG_CLEAR_ON_END:  clear_on_end_q  <= cfg_data_i[0];
        CFG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // step logic: state update, memory access and result of one item
  always_comb begin
    ack_on_d   = ack_on_q;
    pad_zero_d = pad_zero_q;
    idle_d     = idle_q;
    rx_head_d  = rx_head_q;
    rx_tail_d  = rx_tail_q;
    rx_cnt_d   = rx_cnt_q;
    tx_head_d  = tx_head_q;
    tx_tail_d  = tx_tail_q;
    tx_cnt_d   = tx_cnt_q;
    rx_we      = 1'b0;
    rx_re      = 1'b0;
    tx_we      = 1'b0;
    tx_re      = 1'b0;
    rd_need    = 1'b0;
    rd_tx_d    = 1'b0;
    step_res   = '0;

    case (in_item_i.op)
      OP_EVENT: begin
        idle_d   = '0;
        ack_on_d = 1'b1;
        case (st_code) inside
          ST_NO_INFO, ST_ADDR_W, ST_GCALL_W, ST_DATA_NACK, ST_GDATA_NACK,
          ST_STOP: ;
          ST_DATA_ACK, ST_GDATA_ACK: begin
            if (rx_cnt_q == RX_CW'(RX_DEPTH)) begin
              step_res.rx_overflow = 1'b1;
            end else begin
              rx_we     = 1'b1;
              rx_tail_d = (rx_tail_q == RX_AW'(RX_DEPTH - 1)) ? '0
                          : rx_tail_q + RX_AW'(1);
              rx_cnt_d  = rx_cnt_q + RX_CW'(1);
            end
          end
          ST_ADDR_R, ST_TX_ACK: begin
            step_res.tx_loaded = 1'b1;
            if (pad_zero_q && sixteen_bit_q) begin
              pad_zero_d = 1'b0;
            end else if (tx_cnt_q != '0) begin
              tx_re     = 1'b1;
              rd_need   = 1'b1;
              rd_tx_d   = 1'b1;
              tx_head_d = (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0
                          : tx_head_q + TX_AW'(1);
              tx_cnt_d  = tx_cnt_q - TX_CW'(1);
            end else begin
              pad_zero_d = 1'b1;
            end
          end
          ST_TX_NACK, ST_TX_LAST: begin
            if (clear_on_end_q) begin
              rx_head_d = '0;
              rx_tail_d = '0;
              rx_cnt_d  = '0;
              tx_head_d = '0;
              tx_tail_d = '0;
              tx_cnt_d  = '0;
            end
          end
          default: ack_on_d = 1'b0;
        endcase
      end
      OP_PUSH: begin
        if (tx_cnt_q == TX_CW'(TX_DEPTH)) begin
          step_res.tx_overflow = 1'b1;
        end else begin
          tx_we     = 1'b1;
          tx_tail_d = (tx_tail_q == TX_AW'(TX_DEPTH - 1)) ? '0
                      : tx_tail_q + TX_AW'(1);
          tx_cnt_d  = tx_cnt_q + TX_CW'(1);
        end
      end
      OP_POP: begin
        if (rx_cnt_q != '0) begin
          rx_re             = 1'b1;
          rd_need           = 1'b1;
          step_res.rx_valid = 1'b1;
          rx_head_d = (rx_head_q == RX_AW'(RX_DEPTH - 1)) ? '0
                      : rx_head_q + RX_AW'(1);
          rx_cnt_d  = rx_cnt_q - RX_CW'(1);
        end
      end
      OP_TICK: begin
        if (!ack_on_q) begin
          ack_on_d             = 1'b1;
          step_res.bus_restart = 1'b1;
        end else if (st_code == ST_NO_INFO) begin
          if (idle_q > timeout_limit_q) begin
            step_res.bus_reset = 1'b1;
            ack_on_d           = 1'b0;
            idle_d             = '0;
          end else begin
            idle_d = idle_q + 8'd1;
          end
        end
      end
      default: ;
    endcase

    step_res.ack_enable = ack_on_d;
    step_res.rx_level   = LEVEL_W'(rx_cnt_d);
    step_res.tx_level   = LEVEL_W'(tx_cnt_d);

    // memory enables only on an accepted item
    rx_we = rx_we & accept;
    rx_re = rx_re & accept;
    tx_we = tx_we & accept;
    tx_re = tx_re & accept;
  end

  // fifo memories
  i2c_sbe_ram #(
    .WIDTH(8),
    .DEPTH(RX_DEPTH)
  ) u_rx_ram (
    .clk_i  (clk_i),
    .we_i   (rx_we),
    .waddr_i(rx_tail_q),
    .wdata_i(in_item_i.data_byte),
    .re_i   (rx_re),
    .raddr_i(rx_head_q),
    .rdata_o(rx_rdata)
  );

  i2c_sbe_ram #(
    .WIDTH(8),
    .DEPTH(TX_DEPTH)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .we_i   (tx_we),
    .waddr_i(tx_tail_q),
    .wdata_i(in_item_i.data_byte),
    .re_i   (tx_re),
    .raddr_i(tx_head_q),
    .rdata_o(tx_rdata)
  );

  // output register control and read data merge
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rd_pend_d   = 1'b0;
    if (rd_pend_q) begin
      out_valid_d = 1'b1;
      out_d       = pend_q;
      if (rd_tx_q) begin
        out_d.tx_byte = tx_rdata;
      end else begin
        out_d.rx_byte = rx_rdata;
      end
    end else if (accept) begin
      rd_pend_d   = rd_need;
      out_valid_d = ~rd_need;
      out_d       = step_res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_on_q    <= 1'b1;
      pad_zero_q  <= 1'b0;
      idle_q      <= '0;
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      rx_cnt_q    <= '0;
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      tx_cnt_q    <= '0;
      rd_pend_q   <= 1'b0;
      rd_tx_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        ack_on_q   <= ack_on_d;
        pad_zero_q <= pad_zero_d;
        idle_q     <= idle_d;
        rx_head_q  <= rx_head_d;
        rx_tail_q  <= rx_tail_d;
        rx_cnt_q   <= rx_cnt_d;
        tx_head_q  <= tx_head_d;
        tx_tail_q  <= tx_tail_d;
        tx_cnt_q   <= tx_cnt_d;
        rd_tx_q    <= rd_tx_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      pend_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // fill counts stay within the memory depth
  `SBE_ASSERT(a_rx_cnt_range, clk_i, rst_ni, rx_cnt_q <= RX_CW'(RX_DEPTH),
    "receive fifo count beyond depth")
  `SBE_ASSERT(a_tx_cnt_range, clk_i, rst_ni, tx_cnt_q <= TX_CW'(TX_DEPTH),
    "transmit fifo count beyond depth")
  // an empty receive fifo has its pointers together
  `SBE_ASSERT(a_rx_empty_ptr, clk_i, rst_ni, (rx_cnt_q != '0) || (rx_head_q == rx_tail_q),
    "empty receive fifo with pointers apart")
  // a fifo read lands in the output register in the cycle after it is pending
  `SBE_ASSERT_NEXT(a_rd_lands, clk_i, rst_ni, rd_pend_q, out_valid_q && !rd_pend_q,
    "fifo read result not delivered")
  // a bus reset result always drops acknowledge
  `SBE_ASSERT(a_reset_drops_ack, clk_i, rst_ni,
    !(out_valid_q && out_q.bus_reset && out_q.ack_enable),
    "bus reset with acknowledge still enabled")

endmodule
